// ----- design/gha_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gha_pkg
// Shared types and constants of the GHASH accumulator.
// ----------------------------------------------------------------------------
package gha_pkg;

	localparam int BLOCK_W   = 128;
	localparam int HALF_W    = 64;
	localparam int COUNT_W   = 32;
	localparam int NBYTES_W  = 5;
	localparam int OP_W      = 2;
	localparam int DIGIT_W   = 8;
	localparam int DIGITS    = BLOCK_W / DIGIT_W;
	localparam int DIGIT_CNT_W = $clog2(DIGITS);
	localparam int BLOCK_BYTES = BLOCK_W / 8;

	localparam logic [OP_W-1:0] OP_ABSORB_AAD  = 2'd0;
	localparam logic [OP_W-1:0] OP_ABSORB_TEXT = 2'd1;
	localparam logic [OP_W-1:0] OP_FINISH      = 2'd2;

	localparam logic CFG_KEY_HIGH = 1'b0;
	localparam logic CFG_KEY_LOW  = 1'b1;

	localparam logic [NBYTES_W-1:0] NBYTES_MAX = 5'd16;
	localparam logic [COUNT_W-1:0]  COUNT_MAX  = 32'hFFFF_FFFF;

	// bit-reflected reduction constant, top byte 0xE1
	localparam logic [BLOCK_W-1:0] GF_REDUCE = {8'hE1, 120'd0};

	typedef struct packed {
		logic [OP_W-1:0]     operation;
		logic [HALF_W-1:0]   block_high;
		logic [HALF_W-1:0]   block_low;
		logic [NBYTES_W-1:0] valid_bytes;
	} in_item_t;

	typedef struct packed {
		logic [HALF_W-1:0] hash_high;
		logic [HALF_W-1:0] hash_low;
		logic              final_res;
	} out_item_t;

endpackage

// ----- design/gha_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gha stream interfaces
// Valid/ready channels for input blocks and hash results.
// ----------------------------------------------------------------------------
interface gha_in_if;
	import gha_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface gha_out_if;
	import gha_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- design/ghash_accumulator_core.sv -----
`timescale 1ns / 1ps
// sequencing: a multiplying absorb or finish transaction runs every digit through the multiplier,
// then registers the result; an empty absorb or unused operation skips the multiplier
// the core takes no new transaction until the result is handed on; the GF(2^128) multiplier
// consumes 8 multiplier bits per cycle
// reset: accumulator, byte counters and hash key clear to zero, no clearing pass
// ----------------------------------------------------------------------------
// ghash_accumulator_core
// GCM GHASH engine with a digit-serial GF(2^128) multiplier.
// ----------------------------------------------------------------------------
module ghash_accumulator_core (
	input  logic                     clk,
	input  logic                     arst_n,
	gha_in_if.sink                   item,
	gha_out_if.source                result,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [gha_pkg::HALF_W-1:0] cfg_data
);
	import gha_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_BUSY = 1'b1;

	logic                   state_q;
	logic                   done_q;
	logic                   final_q;
	logic                   mul_q;
	logic [DIGIT_CNT_W-1:0] cnt_q;
	logic [BLOCK_W-1:0]     key_q;
	logic [BLOCK_W-1:0]     acc_q;
	logic [BLOCK_W-1:0]     a_q;
	logic [BLOCK_W-1:0]     v_q;
	logic [BLOCK_W-1:0]     z_q;
	logic [COUNT_W-1:0]     aad_cnt_q;
	logic [COUNT_W-1:0]     text_cnt_q;
	logic                   out_vld_q;
	out_item_t              out_q;

	logic                   accept;
	logic                   out_free;
	logic                   emit;
	logic [NBYTES_W-1:0]    n_sat;
	logic [BLOCK_W-1:0]     byte_mask;
	logic [BLOCK_W-1:0]     len_word;
	logic                   is_absorb;
	logic [COUNT_W:0]       aad_sum;
	logic [COUNT_W:0]       text_sum;
	logic [BLOCK_W-1:0]     v_nxt;
	logic [BLOCK_W-1:0]     z_nxt;
	logic [BLOCK_W-1:0]     res_val;

	assign out_free = !out_vld_q || result.ready;
	assign item.ready = (state_q == ST_IDLE);
	assign accept = item.valid && item.ready;
	assign emit = (state_q == ST_BUSY) && done_q && out_free;

	assign n_sat = (item.data.valid_bytes > NBYTES_MAX) ? NBYTES_MAX : item.data.valid_bytes;
	assign is_absorb = (item.data.operation == OP_ABSORB_AAD)
		|| (item.data.operation == OP_ABSORB_TEXT);

	always_comb begin
		for (int i = 0; i < BLOCK_BYTES; i++) begin
			byte_mask[BLOCK_W-1-8*i -: 8] = (NBYTES_W'(i) < n_sat) ? 8'hFF : 8'h00;
		end
	end

	assign len_word = {{(HALF_W-COUNT_W-3){1'b0}}, aad_cnt_q, 3'b000,
		{(HALF_W-COUNT_W-3){1'b0}}, text_cnt_q, 3'b000};

	assign aad_sum  = {1'b0, aad_cnt_q} + (COUNT_W+1)'(n_sat);
	assign text_sum = {1'b0, text_cnt_q} + (COUNT_W+1)'(n_sat);

	// one digit of the multiplier: eight shift-and-add steps
	always_comb begin
		logic [BLOCK_W-1:0] v;
		logic [BLOCK_W-1:0] z;
		v = v_q;
		z = z_q;
		for (int j = 0; j < DIGIT_W; j++) begin
			if (a_q[BLOCK_W-1-j]) begin
				z = z ^ v;
			end
			v = (v >> 1) ^ (v[0] ? GF_REDUCE : '0);
		end
		v_nxt = v;
		z_nxt = z;
	end

	assign res_val = mul_q ? z_q : acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_KEY_HIGH: key_q[BLOCK_W-1:HALF_W] <= cfg_data;
				CFG_KEY_LOW:  key_q[HALF_W-1:0] <= cfg_data;
				default:      key_q <= key_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			done_q     <= 1'b0;
			final_q    <= 1'b0;
			mul_q      <= 1'b0;
			cnt_q      <= '0;
			acc_q      <= '0;
			aad_cnt_q  <= '0;
			text_cnt_q <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_BUSY;
						cnt_q   <= '0;
						final_q <= 1'b0;
						mul_q   <= 1'b0;
						done_q  <= 1'b1;
						if (item.data.operation == OP_FINISH) begin
							final_q    <= 1'b1;
							mul_q      <= 1'b1;
							done_q     <= 1'b0;
							aad_cnt_q  <= '0;
							text_cnt_q <= '0;
						end else if (is_absorb && n_sat != '0) begin
							mul_q  <= 1'b1;
							done_q <= 1'b0;
							if (item.data.operation == OP_ABSORB_AAD) begin
								aad_cnt_q <= aad_sum[COUNT_W] ? COUNT_MAX
									: aad_sum[COUNT_W-1:0];
							end else begin
								text_cnt_q <= text_sum[COUNT_W] ? COUNT_MAX
									: text_sum[COUNT_W-1:0];
							end
						end
					end
				end
				ST_BUSY: begin
					if (!done_q) begin
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == DIGIT_CNT_W'(DIGITS-1)) begin
							done_q <= 1'b1;
						end
					end else if (out_free) begin
						state_q <= ST_IDLE;
						if (final_q) begin
							acc_q <= '0;
						end else if (mul_q) begin
							acc_q <= z_q;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// multiplier datapath and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			v_q <= key_q;
			z_q <= '0;
			if (item.data.operation == OP_FINISH) begin
				a_q <= acc_q ^ len_word;
			end else begin
				a_q <= acc_q ^ ({item.data.block_high, item.data.block_low} & byte_mask);
			end
		end else if (state_q == ST_BUSY && !done_q) begin
			v_q <= v_nxt;
			z_q <= z_nxt;
			a_q <= a_q << DIGIT_W;
		end
		if (emit) begin
			out_q.hash_high <= res_val[BLOCK_W-1:HALF_W];
			out_q.hash_low  <= res_val[HALF_W-1:0];
			out_q.final_res <= final_q;
		end
	end

	assign result.valid = out_vld_q;
	assign result.data  = out_q;

endmodule

// ----- dv/ghash_accumulator_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghash_accumulator_core_tb
// Drives absorb and finish transactions into the GHASH core under several hash
// keys and checks every result against a bit-level GF(2^128) model kept here,
// with random idles on both channels, a long result stall and drain pauses.
// ----------------------------------------------------------------------------
module ghash_accumulator_core_tb;
	import gha_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	localparam int HOLD_CYCLES  = 400;
	localparam int QUIET_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 24;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic              cfg_index;
	logic [HALF_W-1:0] cfg_data;

	gha_in_if  in_ch ();
	gha_out_if out_ch ();

	ghash_accumulator_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (in_ch),
		.result    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// model state
	logic [BLOCK_W-1:0] key_model;
	logic [BLOCK_W-1:0] acc_model;
	logic [COUNT_W-1:0] aad_bytes_model;
	logic [COUNT_W-1:0] text_bytes_model;

	out_item_t expected_hashes[$];

	int errors       = 0;
	int items_sent   = 0;
	bit idle_en      = 1'b0;
	int hold_req     = 0;
	int hold_ack     = 0;
	int hold_left    = 0;
	int quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [BLOCK_W-1:0] gf_mul(input logic [BLOCK_W-1:0] x,
			input logic [BLOCK_W-1:0] h);
		logic [BLOCK_W-1:0] z;
		logic [BLOCK_W-1:0] v;
		z = '0;
		v = h;
		for (int k = 0; k < BLOCK_W; k++) begin
			if (x[BLOCK_W-1-k])
				z ^= v;
			v = v[0] ? ((v >> 1) ^ GF_REDUCE) : (v >> 1);
		end
		return z;
	endfunction

	function automatic logic [COUNT_W-1:0] sat_count(input logic [COUNT_W-1:0] c, input int n);
		logic [COUNT_W:0] s;
		s = {1'b0, c} + (COUNT_W+1)'(n);
		return s[COUNT_W] ? COUNT_MAX : s[COUNT_W-1:0];
	endfunction

	// advances the model by one transaction and returns the expected result
	function automatic out_item_t next_hash(input in_item_t it);
		out_item_t          r;
		logic [BLOCK_W-1:0] mask;
		logic [HALF_W-1:0]  abits;
		logic [HALF_W-1:0]  tbits;
		int                 n;
		n = (it.valid_bytes > NBYTES_MAX) ? int'(NBYTES_MAX) : int'(it.valid_bytes);
		if (it.operation == OP_FINISH) begin
			abits = HALF_W'(aad_bytes_model) << 3;
			tbits = HALF_W'(text_bytes_model) << 3;
			acc_model = gf_mul(acc_model ^ {abits, tbits}, key_model);
			r = {acc_model[BLOCK_W-1:HALF_W], acc_model[HALF_W-1:0], 1'b1};
			acc_model = '0;
			aad_bytes_model = '0;
			text_bytes_model = '0;
			return r;
		end
		if ((it.operation == OP_ABSORB_AAD || it.operation == OP_ABSORB_TEXT) && n != 0) begin
			mask = {BLOCK_W{1'b1}} << (BLOCK_W - 8 * n);
			acc_model = gf_mul(acc_model ^ ({it.block_high, it.block_low} & mask), key_model);
			if (it.operation == OP_ABSORB_AAD)
				aad_bytes_model = sat_count(aad_bytes_model, n);
			else
				text_bytes_model = sat_count(text_bytes_model, n);
		end
		r = {acc_model[BLOCK_W-1:HALF_W], acc_model[HALF_W-1:0], 1'b0};
		return r;
	endfunction

	function automatic logic [BLOCK_W-1:0] rand_block();
		return {$urandom, $urandom, $urandom, $urandom};
	endfunction

	function automatic in_item_t item_of(input logic [OP_W-1:0] op,
			input logic [BLOCK_W-1:0] blk, input int n);
		in_item_t it;
		it.operation   = op;
		it.block_high  = blk[BLOCK_W-1:HALF_W];
		it.block_low   = blk[HALF_W-1:0];
		it.valid_bytes = NBYTES_W'(n);
		return it;
	endfunction

	task automatic send_item(input in_item_t it);
		int gap;
		gap = (idle_en && $urandom_range(99) < 7) ? $urandom_range(1, 4) : 0;
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data  <= it;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		expected_hashes.push_back(next_hash(it));
		items_sent++;
	endtask

	task automatic wait_drain();
		in_ch.valid <= 1'b0;
		while (expected_hashes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_key(input logic [BLOCK_W-1:0] k);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_KEY_HIGH;
		cfg_data  <= k[BLOCK_W-1:HALF_W];
		@(posedge clk);
		cfg_index <= CFG_KEY_LOW;
		cfg_data  <= k[HALF_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		key_model = k;
	endtask

	// well-formed message: full blocks, an optional partial tail, then the lengths
	task automatic send_message(input int aad_blocks, input int text_blocks);
		int n;
		for (int i = 0; i < aad_blocks; i++) begin
			n = (i == aad_blocks - 1 && $urandom_range(1) == 1) ? $urandom_range(1, 16) : 16;
			send_item(item_of(OP_ABSORB_AAD, rand_block(), n));
		end
		for (int i = 0; i < text_blocks; i++) begin
			n = (i == text_blocks - 1 && $urandom_range(1) == 1) ? $urandom_range(1, 16) : 16;
			send_item(item_of(OP_ABSORB_TEXT, rand_block(), n));
		end
		send_item(item_of(OP_FINISH, rand_block(), $urandom_range(0, 31)));
	endtask

	task automatic run_random(input int count);
		int target;
		target = items_sent + count;
		while (items_sent < target) begin
			if ($urandom_range(9) == 0)
				send_item(item_of(OP_W'($urandom_range(0, 3)), rand_block(),
					$urandom_range(0, 31)));
			else
				send_message($urandom_range(0, 3), $urandom_range(0, 5));
		end
	endtask

	// zero key straight out of reset
	task automatic test_reset_key();
		send_item(item_of(OP_ABSORB_AAD, rand_block(), 16));
		send_item(item_of(OP_ABSORB_TEXT, rand_block(), 16));
		send_item(item_of(OP_FINISH, rand_block(), 16));
		wait_drain();
	endtask

	task automatic test_directed();
		write_key(rand_block());
		send_item(item_of(OP_ABSORB_AAD, {BLOCK_W{1'b1}}, 16));
		send_item(item_of(OP_ABSORB_AAD, rand_block(), 0));
		send_item(item_of(OP_ABSORB_AAD, rand_block(), 1));
		send_item(item_of(OP_ABSORB_AAD, rand_block(), 8));
		send_item(item_of(OP_ABSORB_AAD, rand_block(), 9));
		send_item(item_of(OP_ABSORB_TEXT, rand_block(), 15));
		send_item(item_of(OP_ABSORB_TEXT, '0, 16));
		send_item(item_of(OP_ABSORB_TEXT, {BLOCK_W{1'b1}}, 17));
		send_item(item_of(OP_ABSORB_TEXT, rand_block(), 31));
		send_item(item_of(OP_UNUSED, rand_block(), 16));
		// partial block followed by an empty absorb and a finish
		send_item(item_of(OP_ABSORB_AAD, rand_block(), 5));
		send_item(item_of(OP_ABSORB_TEXT, rand_block(), 0));
		send_item(item_of(OP_FINISH, rand_block(), 0));
		send_item(item_of(OP_FINISH, {BLOCK_W{1'b1}}, 31));
		send_item(item_of(OP_ABSORB_TEXT, rand_block(), 3));
		send_item(item_of(OP_FINISH, rand_block(), 16));
		send_item(item_of(OP_ABSORB_AAD, {BLOCK_W{1'b1}}, 16));
		send_item(item_of(OP_UNUSED, '0, 0));
		send_item(item_of(OP_FINISH, '0, 16));
		wait_drain();
	endtask

	task automatic test_random_keyed(input logic [BLOCK_W-1:0] k, input int count,
			input bit with_idles);
		write_key(k);
		idle_en <= with_idles;
		run_random(count);
		wait_drain();
	endtask

	// result channel held off while input keeps coming, then a full drain mid-stream
	task automatic test_backpressure();
		write_key(rand_block());
		idle_en  <= 1'b1;
		hold_req <= hold_req + 1;
		run_random(40);
		wait_drain();
		send_message(1, 2);
		wait_drain();
		send_message(2, 1);
		wait_drain();
	endtask

	task automatic check_result(input out_item_t got);
		out_item_t want;
		if (expected_hashes.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual %h %h final %b",
				$time, got.hash_high, got.hash_low, got.final_res);
			errors++;
			return;
		end
		want = expected_hashes.pop_front();
		if (got.hash_high !== want.hash_high) begin
			$display("%0t: hash_high expected %h actual %h", $time, want.hash_high, got.hash_high);
			errors++;
		end
		if (got.hash_low !== want.hash_low) begin
			$display("%0t: hash_low expected %h actual %h", $time, want.hash_low, got.hash_low);
			errors++;
		end
		if (got.final_res !== want.final_res) begin
			$display("%0t: final_res expected %b actual %b", $time, want.final_res, got.final_res);
			errors++;
		end
	endtask

	// result sink with random stalls and a long hold-off on request
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			check_result(out_ch.data);
		if (hold_req != hold_ack) begin
			hold_ack  = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= !(idle_en && $urandom_range(99) < 7);
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = CFG_KEY_HIGH;
		cfg_data         = '0;
		in_ch.valid      = 1'b0;
		in_ch.data       = '0;
		out_ch.ready     = 1'b0;
		key_model        = '0;
		acc_model        = '0;
		aad_bytes_model  = '0;
		text_bytes_model = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_key();
		test_directed();
		test_random_keyed({BLOCK_W{1'b1}}, 250, 1'b1);
		test_random_keyed(rand_block(), 300, 1'b0);
		test_random_keyed(BLOCK_W'(1), 150, 1'b1);
		test_random_keyed({1'b1, {(BLOCK_W-1){1'b0}}}, 150, 1'b1);
		test_backpressure();
		test_random_keyed(rand_block(), 400, 1'b1);

		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
